### rtl/core/cmr_pkg.sv
// cmr_pkg: shared constants for the catmull-rom curve sampler
// register map, field widths and default parameter values
// no dependencies
package cmr_pkg;

    localparam int COORD_WIDTH_DEF = 20;
    localparam int T_FRAC_BITS_DEF = 16;

    localparam int THRESH_W = 19;
    localparam int STEP_W   = 17;

    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;
    localparam int REG_IDX_W = 1;

    localparam logic [REG_IDX_W-1:0] REG_THRESH = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_STEP   = 1'd1;

    localparam logic [THRESH_W-1:0] THRESH_RST = 19'd16;
    localparam logic [STEP_W-1:0]   STEP_RST   = 17'd7;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

endpackage

### rtl/core/cmr_in_if.sv
// cmr_in_if: input channel of the curve sampler (push or tick words)
// valid/ready handshake; widths from cmr_pkg defaults
interface cmr_in_if #(
    parameter int COORD_WIDTH = cmr_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;

    modport source (output valid, output func, output coord_x, output coord_y, input ready);
    modport sink   (input valid, input func, input coord_x, input coord_y, output ready);
endinterface

### rtl/core/cmr_out_if.sv
// cmr_out_if: result channel of the curve sampler
// valid/ready handshake; widths from cmr_pkg defaults
interface cmr_out_if #(
    parameter int COORD_WIDTH = cmr_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          pixel_valid;
    logic signed [COORD_WIDTH-1:0] pixel_x;
    logic signed [COORD_WIDTH-1:0] pixel_y;
    logic                          segment_done;

    modport source (output valid, output pixel_valid, output pixel_x, output pixel_y,
                    output segment_done, input ready);
    modport sink   (input valid, input pixel_valid, input pixel_x, input pixel_y,
                    input segment_done, output ready);
endinterface

### rtl/core/cmr_mul.sv
// cmr_mul: shared signed multiplier with registered product
// used by the sampler sequencer for every multiply; no dependencies
module cmr_mul #(
    parameter int W = 26
) (
    input  logic                  i_clk,
    input  logic signed [W-1:0]   i_a,
    input  logic signed [W-1:0]   i_b,
    output logic signed [2*W-1:0] o_p
);
    logic signed [2*W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

### rtl/core/catmull_rom_curve_sampler_unit.sv
// catmull_rom_curve_sampler_unit: top level of the catmull-rom curve sampler
// depends on cmr_pkg, cmr_in_if, cmr_out_if and cmr_mul
//
// a push, or a tick that is rejected, goes straight to the emit step, which loads the output
//   register once it is free; an evaluated tick first runs, per axis, a load and three horner
//   multiply steps, then the squares of dx, dy and threshold and the compare; the single shared
//   multiplier carries every multiply, and no new word is taken until the last one is emitted
// reset: synchronous, active low; window, t, last point and count cleared, threshold 16, step 7
module catmull_rom_curve_sampler_unit #(
    parameter int COORD_WIDTH = cmr_pkg::COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = cmr_pkg::T_FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    cmr_in_if.sink                      i_in,
    cmr_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cmr_pkg::ADDR_W-1:0]  paddr,
    input  logic [cmr_pkg::DATA_W-1:0]  pwdata,
    output logic [cmr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    localparam int CW  = COORD_WIDTH;
    localparam int F   = T_FRAC_BITS;
    // operand width: horner accumulator needs coord + 5 bits plus sign, t needs F + 2
    localparam int MW0 = (CW + 6 > F + 2) ? CW + 6 : F + 2;
    localparam int MW  = (MW0 > cmr_pkg::THRESH_W + 1) ? MW0 : cmr_pkg::THRESH_W + 1;
    localparam int PW  = 2 * MW;
    localparam int TW  = F + 1;
    localparam int NTW = ((TW > cmr_pkg::STEP_W) ? TW : cmr_pkg::STEP_W) + 1;

    localparam longint CMAXL = (longint'(1) <<< (CW - 1)) - 1;
    localparam logic signed [MW-1:0] C_MAX = MW'(CMAXL);
    localparam logic signed [MW-1:0] C_MIN = MW'(-CMAXL - 1);
    localparam logic [NTW-1:0] T_ONE = NTW'(1) << F;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_MUL, S_ACC,
        S_DX, S_DXW, S_DY, S_DYW, S_TH, S_THW, S_CMP, S_EMIT
    } t_state;

    // configuration registers
    logic [cmr_pkg::THRESH_W-1:0]  r_thresh;
    logic [cmr_pkg::STEP_W-1:0]    r_step;
    logic [cmr_pkg::REG_IDX_W-1:0] w_idx;

    // architectural state
    logic signed [CW-1:0] r_wx [4];
    logic signed [CW-1:0] r_wy [4];
    logic [2:0]           r_loaded;
    logic [TW-1:0]        r_t;
    logic signed [CW-1:0] r_lx, r_ly;

    // sequencer
    t_state               r_state;
    logic                 r_axis;
    logic [1:0]           r_k;
    logic signed [MW-1:0] r_ca, r_cb, r_cc;
    logic signed [MW-1:0] r_opa, r_opb;
    logic signed [CW-1:0] r_px, r_py;
    logic [PW-1:0]        r_sum;

    // pending result and output register
    logic                 r_res_pv, r_res_done;
    logic signed [CW-1:0] r_res_x, r_res_y;
    logic                 r_ov, r_opv, r_odone;
    logic signed [CW-1:0] r_ox, r_oy;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign w_idx  = paddr[cmr_pkg::ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= cmr_pkg::THRESH_RST;
            r_step   <= cmr_pkg::STEP_RST;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                cmr_pkg::REG_THRESH: r_thresh <= pwdata[cmr_pkg::THRESH_W-1:0];
                cmr_pkg::REG_STEP:   r_step   <= pwdata[cmr_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            cmr_pkg::REG_THRESH: prdata = cmr_pkg::DATA_W'(r_thresh);
            cmr_pkg::REG_STEP:   prdata = cmr_pkg::DATA_W'(r_step);
            default:             prdata = '0;
        endcase
    end

    // ---------------- shared multiplier ----------------
    logic signed [PW-1:0] w_prod;

    cmr_mul #(.W(MW)) u_mul (
        .i_clk (i_clk),
        .i_a   (r_opa),
        .i_b   (r_opb),
        .o_p   (w_prod)
    );

    // ---------------- datapath around the multiplier ----------------
    logic                 w_in_acc, w_slot_free, w_load_out;
    logic [NTW-1:0]       w_nt;
    logic signed [MW-1:0] p0, p1, p2, p3, w_dif;
    logic signed [MW-1:0] w_a, w_b, w_c, w_d;
    logic signed [PW-1:0] w_prod_sh;
    logic signed [MW-1:0] w_sh, w_half_sum, w_val;
    logic signed [CW-1:0] w_sat;
    logic signed [CW:0]   w_dx, w_dy;
    logic [CW:0]          w_ax, w_ay;
    logic [PW-1:0]        w_sq;

    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_slot_free = !r_ov || o_out.ready;
    assign w_load_out  = (r_state == S_EMIT) && w_slot_free;
    assign w_nt        = NTW'(r_t) + NTW'(r_step);

    // control window of the axis in work, sign extended to operand width
    always_comb begin
        if (r_axis) begin
            p0 = MW'(r_wy[0]); p1 = MW'(r_wy[1]); p2 = MW'(r_wy[2]); p3 = MW'(r_wy[3]);
        end else begin
            p0 = MW'(r_wx[0]); p1 = MW'(r_wx[1]); p2 = MW'(r_wx[2]); p3 = MW'(r_wx[3]);
        end
    end

    // curve coefficients, all shift-and-add
    assign w_dif = p1 - p2;
    assign w_a   = p1 <<< 1;
    assign w_b   = p2 - p0;
    assign w_c   = ((p0 <<< 1) + (p2 <<< 2)) - ((p1 <<< 2) + p1 + p3);
    assign w_d   = (p3 - p0) + w_dif + (w_dif <<< 1);

    // floor shift of the product back to coordinate scale
    assign w_prod_sh  = w_prod >>> F;
    assign w_sh       = w_prod_sh[MW-1:0];
    // final halving rounds half upward
    assign w_half_sum = w_sh + r_ca + MW'(1);
    assign w_val      = w_half_sum >>> 1;
    assign w_sat      = (w_val > C_MAX) ? C_MAX[CW-1:0] :
                        (w_val < C_MIN) ? C_MIN[CW-1:0] : w_val[CW-1:0];

    assign w_dx = (CW+1)'(r_px) - (CW+1)'(r_lx);
    assign w_dy = (CW+1)'(r_py) - (CW+1)'(r_ly);
    assign w_ax = w_dx[CW] ? $unsigned(-w_dx) : $unsigned(w_dx);
    assign w_ay = w_dy[CW] ? $unsigned(-w_dy) : $unsigned(w_dy);
    assign w_sq = $unsigned(w_prod);

    assign i_in.ready = (r_state == S_IDLE);

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_axis   <= 1'b0;
            r_k      <= '0;
            r_loaded <= '0;
            r_t      <= '0;
            r_lx     <= '0;
            r_ly     <= '0;
            r_ov     <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_wx[i] <= '0;
                r_wy[i] <= '0;
            end
        end else begin
            // output register: loaded from the emit step, freed once the word is taken
            if (w_load_out) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_in.func == cmr_pkg::FUNC_PUSH) begin
                            for (int i = 0; i < 3; i++) begin
                                r_wx[i] <= r_wx[i+1];
                                r_wy[i] <= r_wy[i+1];
                            end
                            r_wx[3] <= i_in.coord_x;
                            r_wy[3] <= i_in.coord_y;
                            r_t     <= '0;
                            // full window after this push: old third point becomes the second
                            if (r_loaded >= 3'd3) begin
                                r_loaded   <= 3'd4;
                                r_lx       <= r_wx[2];
                                r_ly       <= r_wy[2];
                                r_res_pv   <= 1'b1;
                                r_res_x    <= r_wx[2];
                                r_res_y    <= r_wy[2];
                                r_res_done <= 1'b0;
                            end else begin
                                r_loaded   <= r_loaded + 3'd1;
                                r_res_pv   <= 1'b0;
                                r_res_x    <= '0;
                                r_res_y    <= '0;
                                r_res_done <= 1'b1;
                            end
                            r_state <= S_EMIT;
                        end else if (r_loaded < 3'd4 || w_nt > T_ONE) begin
                            // window not full, or past the end of the segment
                            r_res_pv   <= 1'b0;
                            r_res_x    <= '0;
                            r_res_y    <= '0;
                            r_res_done <= 1'b1;
                            r_state    <= S_EMIT;
                        end else begin
                            r_t     <= w_nt[TW-1:0];
                            r_axis  <= 1'b0;
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    r_ca    <= w_a;
                    r_cb    <= w_b;
                    r_cc    <= w_c;
                    r_opa   <= w_d;
                    r_opb   <= MW'(r_t);
                    r_k     <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    case (r_k)
                        2'd0: begin
                            r_opa   <= w_sh + r_cc;
                            r_k     <= 2'd1;
                            r_state <= S_MUL;
                        end
                        2'd1: begin
                            r_opa   <= w_sh + r_cb;
                            r_k     <= 2'd2;
                            r_state <= S_MUL;
                        end
                        default: begin
                            if (r_axis) begin
                                r_py    <= w_sat;
                                r_state <= S_DX;
                            end else begin
                                r_px    <= w_sat;
                                r_axis  <= 1'b1;
                                r_state <= S_LOAD;
                            end
                        end
                    endcase
                end
                S_DX: begin
                    r_opa   <= MW'(w_ax);
                    r_opb   <= MW'(w_ax);
                    r_state <= S_DXW;
                end
                S_DXW: begin
                    r_state <= S_DY;
                end
                S_DY: begin
                    r_sum   <= w_sq;
                    r_opa   <= MW'(w_ay);
                    r_opb   <= MW'(w_ay);
                    r_state <= S_DYW;
                end
                S_DYW: begin
                    r_state <= S_TH;
                end
                S_TH: begin
                    r_sum   <= r_sum + w_sq;
                    r_opa   <= MW'(r_thresh);
                    r_opb   <= MW'(r_thresh);
                    r_state <= S_THW;
                end
                S_THW: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    // squared distance against squared threshold
                    if (r_sum >= w_sq) begin
                        r_lx     <= r_px;
                        r_ly     <= r_py;
                        r_res_pv <= 1'b1;
                        r_res_x  <= r_px;
                        r_res_y  <= r_py;
                    end else begin
                        r_res_pv <= 1'b0;
                        r_res_x  <= '0;
                        r_res_y  <= '0;
                    end
                    r_res_done <= 1'b0;
                    r_state    <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_slot_free) begin
                        r_opv   <= r_res_pv;
                        r_ox    <= r_res_x;
                        r_oy    <= r_res_y;
                        r_odone <= r_res_done;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.pixel_valid  = r_opv;
    assign o_out.pixel_x      = r_ox;
    assign o_out.pixel_y      = r_oy;
    assign o_out.segment_done = r_odone;

`ifndef SYNTH
    // no new word is taken while one is in work
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !i_in.ready)
        else $error("input taken while a word is in work");

    // an emitted point never comes with segment done
    a_pixel_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.pixel_valid) |-> !o_out.segment_done)
        else $error("emitted point flagged segment done");

    // t stays within one segment
    a_t_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        NTW'(r_t) <= T_ONE)
        else $error("t past the end of the segment");

    // the point count saturates at four
    a_loaded_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded <= 3'd4)
        else $error("point count past four");

    // a word is presented only once the sequencer has finished the item
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == S_EMIT))
        else $error("output word loaded outside the emit step");
`endif

endmodule
